[rtl/tlamp_pkg.sv]
// Shared types, constants and tables of the two-link arm move planner.
package tlamp_pkg;

	localparam int STEP_W = 5;
	localparam int SQRT_STEPS = 16;
	localparam int DIV_STEPS = 2;

	typedef enum logic [1:0] {
		REG_AVOID,
		REG_OVERLAP,
		REG_BIG_SPR,
		REG_SMALL_SPR
	} reg_idx_t;

	typedef struct packed {
		logic load;
		logic prep;
		logic sqrt_step;
		logic cor_init;
		logic cor_sel;
		logic cor_step;
		logic store_a1;
		logic store_a2;
		logic post1;
		logic post2;
		logic post3;
		logic div_init;
		logic div_step;
		logic commit;
		logic [STEP_W-1:0] step;
	} dp_cmd_t;

	typedef struct packed {
		logic unreach;
	} dp_stat_t;

	// atan(2^-k) in 1/65536 deg
	function automatic logic [21:0] atan_q16(input logic [STEP_W-1:0] k);
		logic [21:0] v;
		case (k)
			5'd0: v = 22'd2949120;
			5'd1: v = 22'd1740967;
			5'd2: v = 22'd919879;
			5'd3: v = 22'd466945;
			5'd4: v = 22'd234379;
			5'd5: v = 22'd117304;
			5'd6: v = 22'd58666;
			5'd7: v = 22'd29335;
			5'd8: v = 22'd14668;
			5'd9: v = 22'd7334;
			5'd10: v = 22'd3667;
			5'd11: v = 22'd1833;
			5'd12: v = 22'd917;
			5'd13: v = 22'd458;
			5'd14: v = 22'd229;
			5'd15: v = 22'd115;
			5'd16: v = 22'd57;
			5'd17: v = 22'd29;
			5'd18: v = 22'd14;
			5'd19: v = 22'd7;
			5'd20: v = 22'd4;
			5'd21: v = 22'd2;
			5'd22: v = 22'd1;
			default: v = 22'd0;
		endcase
		return v;
	endfunction

	function automatic logic [3:0] to_cw(input logic [2:0] p);
		logic [3:0] v;
		case (p)
			3'd0: v = 4'd12;
			3'd1: v = 4'd10;
			3'd2: v = 4'd10;
			3'd3: v = 4'd8;
			3'd4: v = 4'd8;
			3'd5: v = 4'd14;
			3'd6: v = 4'd14;
			default: v = 4'd12;
		endcase
		return v;
	endfunction

	function automatic logic [3:0] to_ccw(input logic [2:0] p);
		logic [3:0] v;
		case (p)
			3'd0: v = 4'd4;
			3'd1: v = 4'd2;
			3'd2: v = 4'd2;
			3'd3: v = 4'd0;
			3'd4: v = 4'd0;
			3'd5: v = 4'd6;
			3'd6: v = 4'd6;
			default: v = 4'd4;
		endcase
		return v;
	endfunction

endpackage

[rtl/tlamp_ctrl.sv]
// Sequencing controller of the two-link arm move planner.
module tlamp_ctrl #(
	parameter int CORDIC_ITERATIONS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  tlamp_pkg::dp_stat_t stat,
	output tlamp_pkg::dp_cmd_t  cmd
);
	import tlamp_pkg::*;

	localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(SQRT_STEPS - 1);
	localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DIV_STEPS - 1);
	localparam logic [STEP_W-1:0] COR_LAST = STEP_W'(CORDIC_ITERATIONS - 1);

	typedef enum logic [3:0] {
		S_IDLE, S_PREP, S_SQRT, S_CINIT1, S_CITER1, S_A1, S_CINIT2, S_CITER2,
		S_A2, S_POST1, S_POST2, S_POST3, S_DINIT, S_DIV, S_FIN
	} state_t;

	state_t state_q, state_nxt;
	logic [STEP_W-1:0] cnt_q;
	logic ready_q, valid_q, cnt_last;

	assign in_ready = ready_q;
	assign out_valid = valid_q;

	always_comb begin
		cnt_last = 1'b0;
		case (state_q)
			S_SQRT: cnt_last = (cnt_q == SQRT_LAST);
			S_CITER1, S_CITER2: cnt_last = (cnt_q == COR_LAST);
			S_DIV: cnt_last = (cnt_q == DIV_LAST);
			default: cnt_last = 1'b0;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.step = cnt_q;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid && ready_q) begin
					cmd.load = 1'b1;
					state_nxt = S_PREP;
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_nxt = S_SQRT;
			end
			S_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (cnt_last) state_nxt = S_CINIT1;
			end
			S_CINIT1: begin
				cmd.cor_init = 1'b1;
				state_nxt = S_CITER1;
			end
			S_CITER1: begin
				cmd.cor_step = 1'b1;
				if (cnt_last) state_nxt = S_A1;
			end
			S_A1: begin
				cmd.store_a1 = 1'b1;
				state_nxt = S_CINIT2;
			end
			S_CINIT2: begin
				cmd.cor_init = 1'b1;
				cmd.cor_sel = 1'b1;
				state_nxt = S_CITER2;
			end
			S_CITER2: begin
				cmd.cor_step = 1'b1;
				if (cnt_last) state_nxt = S_A2;
			end
			S_A2: begin
				cmd.store_a2 = 1'b1;
				state_nxt = S_POST1;
			end
			S_POST1: begin
				cmd.post1 = 1'b1;
				state_nxt = S_POST2;
			end
			S_POST2: begin
				cmd.post2 = 1'b1;
				state_nxt = stat.unreach ? S_FIN : S_POST3;
			end
			S_POST3: begin
				cmd.post3 = 1'b1;
				state_nxt = S_DINIT;
			end
			S_DINIT: begin
				cmd.div_init = 1'b1;
				state_nxt = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_last) state_nxt = S_FIN;
			end
			S_FIN: begin
				if (!valid_q || out_ready) begin
					cmd.commit = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			ready_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			ready_q <= (state_nxt == S_IDLE);
			if (state_nxt != state_q || cnt_last)
				cnt_q <= '0;
			else
				cnt_q <= cnt_q + 1'b1;
			if (cmd.commit)
				valid_q <= 1'b1;
			else if (out_ready)
				valid_q <= 1'b0;
		end
	end

endmodule

[rtl/tlamp_dp.sv]
// Datapath of the two-link arm move planner: square roots, CORDIC, step maths.
module tlamp_dp #(
	parameter int GRID_COLUMNS = 12,
	parameter int GRID_ROWS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tlamp_pkg::dp_cmd_t  cmd,
	output tlamp_pkg::dp_stat_t stat,
	input  logic [3:0]          grid_column,
	input  logic [3:0]          grid_row,
	input  logic [3:0]          phase_now,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	output logic [35:0]         result
);
	import tlamp_pkg::*;

	localparam logic [3:0] COL_MAX = 4'(GRID_COLUMNS - 1);
	localparam logic [3:0] ROW_MAX = 4'(GRID_ROWS - 1);
	localparam logic signed [18:0] H19 = 19'sd46080;
	localparam logic signed [18:0] F19 = 19'sd92160;
	localparam logic [23:0] RECIP45 = 24'd11930465;

	function automatic logic signed [17:0] wrap1(input logic signed [18:0] v);
		logic signed [18:0] r;
		if (v > H19) r = v - F19;
		else if (v <= -H19) r = v + F19;
		else r = v;
		return 18'(r);
	endfunction

	function automatic logic signed [17:0] rnd8(input logic signed [25:0] z);
		logic signed [25:0] m;
		if (!z[25]) begin
			m = (z + 26'sd128) >>> 8;
			return 18'(m);
		end
		m = (-z + 26'sd128) >>> 8;
		return -18'(m);
	endfunction

	// configuration
	logic [6:0] avoid_q, overlap_q;
	logic [12:0] big_spr_q;
	logic [15:0] small_spr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avoid_q <= 7'd45;
			overlap_q <= 7'd5;
			big_spr_q <= 13'd192;
			small_spr_q <= 16'd2048;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_AVOID: avoid_q <= cfg_data[6:0];
				REG_OVERLAP: overlap_q <= cfg_data[6:0];
				REG_BIG_SPR: big_spr_q <= cfg_data[12:0];
				REG_SMALL_SPR: small_spr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stored arm state
	logic signed [19:0] acc_q;
	logic signed [13:0] shoulder_q;

	// working registers
	logic [3:0] col_q, row_q, phase_q;
	logic [31:0] sv_q, hv_q;
	logic [32:0] sr_q, hr_q;
	logic [19:0] wr_q;
	logic wneg_q;
	logic signed [35:0] cx_q, cy_q;
	logic signed [25:0] cz_q;
	logic signed [17:0] a1_q, a2_q;
	logic signed [17:0] t1a_q, t2a_q, t1b_q, t2b_q;
	logic signed [18:0] lo_q;
	logic unreach_q;
	logic signed [18:0] da_q, db_q, d_q;
	logic signed [32:0] num_q;
	logic signed [35:0] nsm_q;
	logic [22:0] rem1_q, rem2_q;
	logic [17:0] quo1_q, quo2_q;
	logic sgn1_q, sgn2_q;

	assign stat.unreach = unreach_q;

	// cell centre in mm
	logic signed [9:0] xc, yc, x_mm, y_mm;
	logic signed [20:0] r2w;
	logic [16:0] r2;
	logic signed [17:0] h2;
	assign xc = $signed({5'd0, col_q, 1'b0}) - 10'sd1 * 10'(GRID_COLUMNS - 1);
	assign yc = $signed({5'd0, row_q, 1'b0}) - 10'sd1 * 10'(GRID_ROWS - 1);
	assign x_mm = 10'(xc * 10'sd12);
	assign y_mm = 10'(yc * 10'sd12);
	assign r2w = 21'(x_mm) * 21'(x_mm) + 21'(y_mm) * 21'(y_mm);
	assign r2 = r2w[16:0];
	assign h2 = 18'sd31684 - $signed({1'b0, r2});

	// square root step
	logic [5:0] bsh;
	logic [32:0] sb, rb_s, rb_h;
	assign bsh = 6'(30) - 6'({cmd.step, 1'b0});
	assign sb = 33'd1 << bsh;
	assign rb_s = sr_q + sb;
	assign rb_h = hr_q + sb;

	// CORDIC operands
	logic signed [35:0] cix, ciy, cxs, cys;
	logic signed [25:0] atn;
	always_comb begin
		if (cmd.cor_sel) begin
			cix = $signed({4'd0, sr_q[15:0], 16'd0});
			ciy = $signed({4'd0, hr_q[15:0], 16'd0});
		end else begin
			cix = 36'(x_mm) <<< 24;
			ciy = 36'(y_mm) <<< 24;
		end
	end
	assign cxs = cx_q >>> cmd.step;
	assign cys = cy_q >>> cmd.step;
	assign atn = $signed({4'd0, atan_q16(cmd.step)});

	// post1: candidate angles and band test
	logic signed [18:0] band, lo, hi;
	logic signed [17:0] p1a, p2a, p1b, p2b;
	logic bana, banb;
	assign band = $signed({4'd0, avoid_q, 8'd0});
	assign lo = -19'sd23040 - band;
	assign hi = -19'sd23040 + band;
	assign p1a = wrap1(19'(a1_q) + 19'(a2_q));
	assign p2a = wrap1(-19'(a2_q) - 19'(a2_q));
	assign p1b = wrap1(19'(a1_q) - 19'(a2_q));
	assign p2b = wrap1(19'(a2_q) + 19'(a2_q));
	assign bana = (19'(p1a) >= lo) && (19'(p1a) <= hi);
	assign banb = (19'(p1b) >= lo) && (19'(p1b) <= hi);

	// post2: elbow moves
	logic signed [18:0] ct, cur, dfa, dfb, sda, sdb, ov, da, db;
	logic signed [20:0] ea, eb;
	assign ct = wneg_q ? -$signed({1'b0, wr_q[17:0]}) : $signed({1'b0, wr_q[17:0]});
	assign cur = 19'(wrap1(ct));
	assign ov = $signed({4'd0, overlap_q, 8'd0});
	assign dfa = 19'(t2a_q) - cur;
	assign dfb = 19'(t2b_q) - cur;
	assign sda = (dfa > H19) ? dfa - F19 : ((dfa < -H19) ? dfa + F19 : dfa);
	assign sdb = (dfb > H19) ? dfb - F19 : ((dfb < -H19) ? dfb + F19 : dfb);
	assign ea = 21'(acc_q) + 21'(sda);
	assign eb = 21'(acc_q) + 21'(sdb);
	always_comb begin
		if (ea > 21'sd69120 + 21'(ov)) da = sda - F19;
		else if (ea < -21'sd23040 - 21'(ov)) da = sda + F19;
		else da = sda;
		if (eb > 21'sd46080 + 21'(ov)) db = sdb - F19;
		else if (eb < -21'sd46080 - 21'(ov)) db = sdb + F19;
		else db = sdb;
	end

	// post3: pick solution, scale to steps
	logic signed [18:0] ada, adb, t1, tt, dsel;
	assign ada = da_q < 0 ? -da_q : da_q;
	assign adb = db_q < 0 ? -db_q : db_q;
	assign t1 = (ada <= adb) ? 19'(t1a_q) : 19'(t1b_q);
	assign dsel = (ada <= adb) ? da_q : db_q;
	assign tt = (t1 > -H19 && t1 <= lo_q) ? t1 + F19 : t1;

	// divide by 92160 = 2048 * 45: shift, then reciprocal of 45, one product a cycle
	logic [22:0] dq;
	logic [46:0] dprod;
	assign dq = cmd.step[0] ? rem2_q : rem1_q;
	assign dprod = 47'(dq) * 47'(RECIP45);

	// commit
	logic signed [18:0] q1s;
	logic signed [13:0] pos;
	logic signed [14:0] dbig, abig;
	logic [11:0] bcnt;
	logic [15:0] scnt;
	logic sccw, restart;
	logic [3:0] rphase;
	logic signed [20:0] accn;
	logic signed [19:0] acc_sat;
	always_comb begin
		q1s = sgn1_q ? -$signed({1'b0, quo1_q}) : $signed({1'b0, quo1_q});
		if (q1s > 19'sd8191) pos = 14'sd8191;
		else if (q1s < -19'sd8192) pos = -14'sd8192;
		else pos = 14'(q1s);
		dbig = 15'(pos) - 15'(shoulder_q);
		abig = dbig < 0 ? -dbig : dbig;
		bcnt = (abig > 15'sd4095) ? 12'd4095 : 12'(abig);
		scnt = (quo2_q > 18'd65535) ? 16'hFFFF : quo2_q[15:0];
		sccw = !sgn2_q && (quo2_q != '0);
		restart = 1'b0;
		rphase = 4'd0;
		if (!phase_q[3] && !sccw) begin
			restart = 1'b1;
			rphase = to_cw(phase_q[2:0]);
		end else if (phase_q[3] && sccw) begin
			restart = 1'b1;
			rphase = to_ccw(phase_q[2:0]);
		end
		accn = 21'(acc_q) + 21'(d_q);
		if (accn > 21'sd524287) acc_sat = 20'sd524287;
		else if (accn < -21'sd524288) acc_sat = -20'sd524288;
		else acc_sat = 20'(accn);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			shoulder_q <= '0;
		end else if (cmd.commit && !unreach_q) begin
			acc_q <= acc_sat;
			shoulder_q <= pos;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			col_q <= (grid_column > COL_MAX) ? COL_MAX : grid_column;
			row_q <= (grid_row > ROW_MAX) ? ROW_MAX : grid_row;
			phase_q <= phase_now;
		end
		if (cmd.prep) begin
			sv_q <= {r2[15:0], 16'd0} | (r2[16] ? 32'h8000_0000 : 32'd0);
			hv_q <= (h2 > 0) ? {h2[15:0], 16'd0} : 32'd0;
			sr_q <= '0;
			hr_q <= '0;
			wneg_q <= acc_q[19];
			wr_q <= acc_q[19] ? 20'(-acc_q) : 20'(acc_q);
		end
		if (cmd.sqrt_step) begin
			if ({1'b0, sv_q} >= rb_s) begin
				sv_q <= 32'({1'b0, sv_q} - rb_s);
				sr_q <= (sr_q >> 1) + sb;
			end else begin
				sr_q <= sr_q >> 1;
			end
			if ({1'b0, hv_q} >= rb_h) begin
				hv_q <= 32'({1'b0, hv_q} - rb_h);
				hr_q <= (hr_q >> 1) + sb;
			end else begin
				hr_q <= hr_q >> 1;
			end
			if (wr_q >= 20'd92160)
				wr_q <= wr_q - 20'd92160;
		end
		if (cmd.cor_init) begin
			if (cix < 0) begin
				if (ciy >= 0) begin
					cx_q <= ciy;
					cy_q <= -cix;
					cz_q <= 26'sd5898240;
				end else begin
					cx_q <= -ciy;
					cy_q <= cix;
					cz_q <= -26'sd5898240;
				end
			end else begin
				cx_q <= cix;
				cy_q <= ciy;
				cz_q <= '0;
			end
		end
		if (cmd.cor_step) begin
			if (cy_q >= 0) begin
				cx_q <= cx_q + cys;
				cy_q <= cy_q - cxs;
				cz_q <= cz_q + atn;
			end else begin
				cx_q <= cx_q - cys;
				cy_q <= cy_q + cxs;
				cz_q <= cz_q - atn;
			end
		end
		if (cmd.store_a1)
			a1_q <= (x_mm == 0 && y_mm == 0) ? 18'sd0 : rnd8(cz_q);
		if (cmd.store_a2)
			a2_q <= rnd8(cz_q);
		if (cmd.post1) begin
			t1a_q <= bana ? p1b : p1a;
			t2a_q <= bana ? p2b : p2a;
			t1b_q <= banb ? p1a : p1b;
			t2b_q <= banb ? p2a : p2b;
			lo_q <= lo;
			unreach_q <= bana && banb;
		end
		if (cmd.post2) begin
			da_q <= da;
			db_q <= db;
		end
		if (cmd.post3) begin
			d_q <= dsel;
			num_q <= 33'(tt) * 33'($signed({1'b0, big_spr_q}));
			nsm_q <= 36'(dsel) * 36'($signed({1'b0, small_spr_q}));
		end
		if (cmd.div_init) begin
			sgn1_q <= num_q[32];
			sgn2_q <= nsm_q[35];
			rem1_q <= 23'((34'(num_q[32] ? -num_q : num_q) + 34'd46080) >> 11);
			rem2_q <= 23'((34'(nsm_q[35] ? -nsm_q : nsm_q) + 34'd46080) >> 11);
			quo1_q <= '0;
			quo2_q <= '0;
		end
		if (cmd.div_step) begin
			if (!cmd.step[0])
				quo1_q <= dprod[46:29];
			else
				quo2_q <= dprod[46:29];
		end
		if (cmd.commit) begin
			if (unreach_q)
				result <= {1'b1, 35'd0};
			else
				result <= {1'b0, rphase, restart, sccw, scnt, !dbig[14] && dbig != 0, bcnt};
		end
	end

endmodule

[rtl/two_link_arm_move_planner.sv]
// Top level of the two-link arm move planner.
//
//  channel   dir  handshake              payload
//  s_*       in   s_tvalid / s_tready    s_tdata  [15:0] request word
//  m_*       out  m_tvalid / m_tready    m_tdata  [39:0] move word
//  cfg_*     in   cfg_valid / cfg_ready  cfg_index [1:0], cfg_data [15:0]
//
// The 16-step square root and the two CORDIC passes make up most of the work
// of one request. An unreachable target skips the step scaling.
// s_tready is high only while no request is in work; a finished word waits in
// the output register while the next request is taken, and the next one stalls
// in its last cycle until that word has gone.
// A reachable move updates the stored shoulder and elbow positions when its word
// is loaded into the output register.
// Reset clears both positions and loads the register defaults; cfg is always ready.
module two_link_arm_move_planner #(
	parameter int GRID_COLUMNS = 12,
	parameter int GRID_ROWS = 8,
	parameter int CORDIC_ITERATIONS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // grid_column, grid_row, phase_now, zero fill
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // big_step_count, big_ccw, small_step_count, small_ccw,
	                               // phase_restart, restart_phase, unreachable, zero fill
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import tlamp_pkg::*;

	dp_cmd_t cmd;
	dp_stat_t stat;
	logic [35:0] result;

	assign cfg_ready = 1'b1;
	assign m_tdata = {4'd0, result};

	tlamp_ctrl #(
		.CORDIC_ITERATIONS(CORDIC_ITERATIONS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.stat(stat),
		.cmd(cmd)
	);

	tlamp_dp #(
		.GRID_COLUMNS(GRID_COLUMNS),
		.GRID_ROWS(GRID_ROWS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.grid_column(s_tdata[3:0]),
		.grid_row(s_tdata[7:4]),
		.phase_now(s_tdata[11:8]),
		.cfg_we(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.result(result)
	);

endmodule
